@@ rtl/shar_pkg.sv @@
// shared types, codes and reset constants for the shunt auto-ranging unit
package shar_pkg;

    // default current width, microamps, signed
    localparam int CURRENT_BITS_DEF = 26;

    // configuration field widths
    localparam int MV_W      = 15;
    localparam int THR_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 25;
    localparam int SHUNT_W   = 20;
    localparam int RANGE_W   = 2;
    localparam int TOTAL_W   = 8;

    // register reset values
    localparam logic [MV_W-1:0]  UVLO_ENTER_RST = 15'd1200;
    localparam logic [MV_W-1:0]  UVLO_EXIT_RST  = 15'd1500;
    localparam logic [THR_W-1:0] DOWN_R0_RST    = 25'd80000;
    localparam logic [THR_W-1:0] DOWN_R1_RST    = 25'd8000;
    localparam logic [THR_W-1:0] UP_R1_RST      = 25'd100000;
    localparam logic [THR_W-1:0] UP_R2_RST      = 25'd10000;

    // range codes, 0 carries the largest current
    localparam logic [RANGE_W-1:0] RANGE_0 = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_1 = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_2 = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_3 = 2'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UVLO_ENTER = 3'd0,
        CFG_UVLO_EXIT  = 3'd1,
        CFG_DOWN_R0    = 3'd2,
        CFG_DOWN_R1    = 3'd3,
        CFG_UP_R1      = 3'd4,
        CFG_UP_R2      = 3'd5
    } t_cfg_idx;

    // item operation codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // live threshold set
    typedef struct packed {
        logic [MV_W-1:0]  uvlo_enter_mv;
        logic [MV_W-1:0]  uvlo_exit_mv;
        logic [THR_W-1:0] down_from_range0;
        logic [THR_W-1:0] down_from_range1;
        logic [THR_W-1:0] up_from_range1;
        logic [THR_W-1:0] up_from_range2;
    } t_cfg;

    // per-step status flags
    typedef struct packed {
        logic [RANGE_W-1:0] active_range;
        logic               range_changed;
        logic               recal_request;
        logic               locked_out;
        logic               lockout_entered;
        logic               reading_valid;
    } t_flags;

endpackage

@@ rtl/shar_if.sv @@
// valid/ready channel interfaces for samples, results and configuration writes

interface shar_in_if #(
    parameter int CURRENT_BITS = shar_pkg::CURRENT_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [shar_pkg::SHUNT_W-1:0] shunt_uv;
    logic signed [CURRENT_BITS-1:0]      sense_ua;
    logic [shar_pkg::MV_W-1:0]           bus_mv;

    modport source (output valid, operation, shunt_uv, sense_ua, bus_mv, input ready);
    modport sink   (input valid, operation, shunt_uv, sense_ua, bus_mv, output ready);
endinterface

interface shar_out_if #(
    parameter int CURRENT_BITS = shar_pkg::CURRENT_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [shar_pkg::RANGE_W-1:0]       active_range;
    logic                               range_changed;
    logic                               recal_request;
    logic                               locked_out;
    logic                               lockout_entered;
    logic                               reading_valid;
    logic signed [CURRENT_BITS-1:0]     max_current;
    logic signed [CURRENT_BITS-1:0]     min_current;
    logic [shar_pkg::TOTAL_W-1:0]       recal_total;

    modport source (output valid, active_range, range_changed, recal_request, locked_out,
                    lockout_entered, reading_valid, max_current, min_current, recal_total,
                    input ready);
    modport sink   (input valid, active_range, range_changed, recal_request, locked_out,
                    lockout_entered, reading_valid, max_current, min_current, recal_total,
                    output ready);
endinterface

interface shar_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [shar_pkg::CFG_IDX_W-1:0] index;
    logic [shar_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/shar_cfg_regs.sv @@
// configuration register file: lockout and range thresholds
module shar_cfg_regs
    import shar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode one write beat; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_idx))
                CFG_UVLO_ENTER: n_cfg.uvlo_enter_mv    = i_data[MV_W-1:0];
                CFG_UVLO_EXIT:  n_cfg.uvlo_exit_mv     = i_data[MV_W-1:0];
                CFG_DOWN_R0:    n_cfg.down_from_range0 = i_data[THR_W-1:0];
                CFG_DOWN_R1:    n_cfg.down_from_range1 = i_data[THR_W-1:0];
                CFG_UP_R1:      n_cfg.up_from_range1   = i_data[THR_W-1:0];
                CFG_UP_R2:      n_cfg.up_from_range2   = i_data[THR_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uvlo_enter_mv    <= UVLO_ENTER_RST;
            r_cfg.uvlo_exit_mv     <= UVLO_EXIT_RST;
            r_cfg.down_from_range0 <= DOWN_R0_RST;
            r_cfg.down_from_range1 <= DOWN_R1_RST;
            r_cfg.up_from_range1   <= UP_R1_RST;
            r_cfg.up_from_range2   <= UP_R2_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/shar_step.sv @@
// per-sample update: recal check, lockout hysteresis, range selector, min/max state
module shar_step
    import shar_pkg::*;
#(
    parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  t_cfg                           i_cfg,
    input  logic                           i_op,
    input  logic signed [SHUNT_W-1:0]      i_shunt,
    input  logic signed [CURRENT_BITS-1:0] i_cur,
    input  logic [MV_W-1:0]                i_bus,
    output t_flags                         o_flags,
    output logic signed [CURRENT_BITS-1:0] o_max,
    output logic signed [CURRENT_BITS-1:0] o_min,
    output logic [TOTAL_W-1:0]             o_total
);

    // compare width holds both the signed current and an unsigned threshold
    localparam int CmpW = ((CURRENT_BITS > THR_W) ? CURRENT_BITS : THR_W) + 1;
    localparam logic signed [CURRENT_BITS-1:0] CurGreatest =
        {1'b0, {(CURRENT_BITS-1){1'b1}}};

    logic [RANGE_W-1:0]             r_range, n_range;
    logic                           r_uv, n_uv;
    logic signed [CURRENT_BITS-1:0] r_max, n_max;
    logic signed [CURRENT_BITS-1:0] r_min, n_min;
    logic [TOTAL_W-1:0]             r_cnt, n_cnt;

    logic signed [CmpW-1:0] w_cur;
    logic signed [CmpW-1:0] w_d0, w_d1, w_u1, w_u2;
    logic                   w_changed, w_recal, w_entered, w_valid;

    // widen current and thresholds to one signed compare width
    assign w_cur = CmpW'(i_cur);
    assign w_d0  = $signed({{(CmpW-THR_W){1'b0}}, i_cfg.down_from_range0});
    assign w_d1  = $signed({{(CmpW-THR_W){1'b0}}, i_cfg.down_from_range1});
    assign w_u1  = $signed({{(CmpW-THR_W){1'b0}}, i_cfg.up_from_range1});
    assign w_u2  = $signed({{(CmpW-THR_W){1'b0}}, i_cfg.up_from_range2});

    // next state and step flags
    always_comb begin
        n_range   = r_range;
        n_uv      = r_uv;
        n_max     = r_max;
        n_min     = r_min;
        n_cnt     = r_cnt;
        w_changed = 1'b0;
        w_recal   = 1'b0;
        w_entered = 1'b0;
        w_valid   = 1'b0;
        if (t_op'(i_op) == OP_CLEAR) begin
            n_max = '0;
            n_min = CurGreatest;
        end else if (i_cur == '0 && i_shunt != '0) begin
            // zero current with shunt voltage present: calibration lost
            w_recal = 1'b1;
            n_cnt   = r_cnt + TOTAL_W'(1);
        end else begin
            // lockout hysteresis, a negative current also locks out
            if (r_uv) begin
                if (i_bus >= i_cfg.uvlo_exit_mv) begin
                    n_uv = 1'b0;
                end
            end else if (i_bus < i_cfg.uvlo_enter_mv || i_cur[CURRENT_BITS-1]) begin
                n_uv      = 1'b1;
                w_entered = 1'b1;
                if (r_range != RANGE_0) begin
                    n_range   = RANGE_0;
                    w_changed = 1'b1;
                end
            end
            // range selector and min/max tracking while unlocked
            if (!n_uv) begin
                case (r_range)
                    RANGE_0: begin
                        if (w_cur <= w_d0) begin
                            n_range   = RANGE_1;
                            w_changed = 1'b1;
                        end
                    end
                    RANGE_1: begin
                        if (w_cur <= w_d1) begin
                            n_range   = RANGE_2;
                            w_changed = 1'b1;
                        end else if (w_cur > w_u1) begin
                            n_range   = RANGE_0;
                            w_changed = 1'b1;
                        end
                    end
                    default: begin
                        // code three behaves as the smallest range
                        if (w_cur > w_u2) begin
                            n_range   = RANGE_1;
                            w_changed = 1'b1;
                        end
                    end
                endcase
                if (!w_changed) begin
                    if (i_cur > r_max) begin
                        n_max = i_cur;
                    end
                    if (i_cur < r_min) begin
                        n_min = i_cur;
                    end
                    w_valid = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_0;
            r_uv    <= 1'b0;
            r_max   <= '0;
            r_min   <= CurGreatest;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_range <= n_range;
            r_uv    <= n_uv;
            r_max   <= n_max;
            r_min   <= n_min;
            r_cnt   <= n_cnt;
        end
    end

    // result view of this step
    always_comb begin
        o_flags.active_range    = n_range;
        o_flags.range_changed   = w_changed;
        o_flags.recal_request   = w_recal;
        o_flags.locked_out      = n_uv;
        o_flags.lockout_entered = w_entered;
        o_flags.reading_valid   = w_valid;
    end

    assign o_max   = n_max;
    assign o_min   = n_min;
    assign o_total = n_cnt;

endmodule

@@ rtl/shunt_autorange_uvlo_minmax_unit.sv @@
// top level: shunt auto-ranging with undervoltage lockout and min/max current tracking
// One result beat per input beat, in order. A beat is captured in the input register,
// then evaluated and written to the result register once that register is free; a new
// beat is taken every cycle while the result side is not backed up, as the state update
// (range, lockout flag, min/max, recal counter) between the two registers is
// combinational. The input side stalls only when a beat sits in the input register and
// the result register holds a beat that the sink has not taken. Configuration writes are
// taken every cycle and must only be issued while no beat is in flight.
module shunt_autorange_uvlo_minmax_unit
    import shar_pkg::*;
#(
    parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shar_cfg_if.sink    i_cfg,
    shar_in_if.sink     i_in,
    shar_out_if.source  o_out
);

    t_cfg   w_cfg;
    t_flags w_flags;
    logic signed [CURRENT_BITS-1:0] w_max, w_min;
    logic [TOTAL_W-1:0]             w_total;

    // input register
    logic                           r_in_valid;
    logic                           r_op;
    logic signed [SHUNT_W-1:0]      r_shunt;
    logic signed [CURRENT_BITS-1:0] r_cur;
    logic [MV_W-1:0]                r_bus;

    // result register
    logic                           r_out_valid;
    t_flags                         r_flags;
    logic signed [CURRENT_BITS-1:0] r_max, r_min;
    logic [TOTAL_W-1:0]             r_total;

    logic w_in_acc, w_load;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign w_load      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_load;
    assign w_in_acc    = i_in.valid && i_in.ready;

    shar_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    shar_step #(
        .CURRENT_BITS (CURRENT_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_cfg   (w_cfg),
        .i_op    (r_op),
        .i_shunt (r_shunt),
        .i_cur   (r_cur),
        .i_bus   (r_bus),
        .o_flags (w_flags),
        .o_max   (w_max),
        .o_min   (w_min),
        .o_total (w_total)
    );

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_in.operation;
            r_shunt <= i_in.shunt_uv;
            r_cur   <= i_in.sense_ua;
            r_bus   <= i_in.bus_mv;
        end
    end

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_flags <= w_flags;
            r_max   <= w_max;
            r_min   <= w_min;
            r_total <= w_total;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.active_range    = r_flags.active_range;
    assign o_out.range_changed   = r_flags.range_changed;
    assign o_out.recal_request   = r_flags.recal_request;
    assign o_out.locked_out      = r_flags.locked_out;
    assign o_out.lockout_entered = r_flags.lockout_entered;
    assign o_out.reading_valid   = r_flags.reading_valid;
    assign o_out.max_current     = r_max;
    assign o_out.min_current     = r_min;
    assign o_out.recal_total     = r_total;

    // range code three is never produced
    a_no_range3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_flags.active_range != RANGE_3)
        else $error("range code three reported");

    // a range switch and a min/max update exclude each other
    a_change_xor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_flags.range_changed && r_flags.reading_valid))
        else $error("range change reported together with a valid reading");

    // entering lockout leaves the block locked in range 0
    a_entry_range0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.lockout_entered) |->
            (r_flags.locked_out && r_flags.active_range == RANGE_0))
        else $error("lockout entry without range 0");

    // an empty result stage never holds off the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result stage");

endmodule

@@ verif/tb_shunt_autorange_uvlo_minmax_unit.sv @@
// self-checking testbench for the shunt auto-ranging unit with undervoltage lockout
module tb_shunt_autorange_uvlo_minmax_unit
    import shar_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = CURRENT_BITS_DEF;
    localparam logic signed [CB-1:0] CUR_TOP = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CUR_BOT = {1'b1, {(CB-1){1'b0}}};
    localparam longint CUR_HI = (longint'(1) << (CB-1)) - 1;
    localparam longint CUR_LO = -(longint'(1) << (CB-1));
    localparam int MV_TOP = (1 << MV_W) - 1;
    localparam logic [THR_W-1:0] THR_TOP = {THR_W{1'b1}};

    // one result beat as seen on the output channel
    typedef struct packed {
        t_flags               flags;
        logic signed [CB-1:0] max_cur;
        logic signed [CB-1:0] min_cur;
        logic [TOTAL_W-1:0]   total;
    } t_meter_result;

    // predicts ranging, lockout and min/max per beat and checks result beats in order
    class meter_scoreboard;
        t_cfg                 thr;
        logic [RANGE_W-1:0]   range_sel;
        logic                 uv_lock;
        logic signed [CB-1:0] max_seen;
        logic signed [CB-1:0] min_seen;
        logic [TOTAL_W-1:0]   recal_cnt;
        t_meter_result        expected_q[$];
        int errors;
        int n_checked;
        int n_recal;
        int n_switch;
        int n_lockouts;
        int n_clears;

        function void reset_state();
            thr = '{UVLO_ENTER_RST, UVLO_EXIT_RST, DOWN_R0_RST, DOWN_R1_RST,
                    UP_R1_RST, UP_R2_RST};
            range_sel = RANGE_0;
            uv_lock   = 1'b0;
            max_seen  = '0;
            min_seen  = CUR_TOP;
            recal_cnt = '0;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                CFG_UVLO_ENTER: thr.uvlo_enter_mv    = d[MV_W-1:0];
                CFG_UVLO_EXIT:  thr.uvlo_exit_mv     = d[MV_W-1:0];
                CFG_DOWN_R0:    thr.down_from_range0 = d[THR_W-1:0];
                CFG_DOWN_R1:    thr.down_from_range1 = d[THR_W-1:0];
                CFG_UP_R1:      thr.up_from_range1   = d[THR_W-1:0];
                CFG_UP_R2:      thr.up_from_range2   = d[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_op op, logic signed [SHUNT_W-1:0] shunt,
                                 logic signed [CB-1:0] cur, logic [MV_W-1:0] bus);
            t_meter_result r;
            longint c;
            logic changed;
            logic entered;
            logic recal;
            logic valid;
            c       = cur;
            changed = 1'b0;
            entered = 1'b0;
            recal   = 1'b0;
            valid   = 1'b0;
            if (op == OP_CLEAR) begin
                max_seen = '0;
                min_seen = CUR_TOP;
                n_clears++;
            end else if (cur == 0 && shunt != 0) begin
                // lost calibration: only the counter moves
                recal = 1'b1;
                recal_cnt = recal_cnt + 1'b1;
                n_recal++;
            end else begin
                // lockout with hysteresis, entry forces the largest range
                if (uv_lock) begin
                    if (bus >= thr.uvlo_exit_mv)
                        uv_lock = 1'b0;
                end else if (bus < thr.uvlo_enter_mv || cur < 0) begin
                    uv_lock = 1'b1;
                    entered = 1'b1;
                    if (range_sel != RANGE_0) begin
                        range_sel = RANGE_0;
                        changed = 1'b1;
                    end
                end
                // range stepping, then min/max if the range held
                if (!uv_lock) begin
                    case (range_sel)
                        RANGE_0: begin
                            if (c <= longint'(thr.down_from_range0)) begin
                                range_sel = RANGE_1;
                                changed = 1'b1;
                            end
                        end
                        RANGE_1: begin
                            if (c <= longint'(thr.down_from_range1)) begin
                                range_sel = RANGE_2;
                                changed = 1'b1;
                            end else if (c > longint'(thr.up_from_range1)) begin
                                range_sel = RANGE_0;
                                changed = 1'b1;
                            end
                        end
                        default: begin
                            if (c > longint'(thr.up_from_range2)) begin
                                range_sel = RANGE_1;
                                changed = 1'b1;
                            end
                        end
                    endcase
                    if (!changed) begin
                        if (cur > max_seen)
                            max_seen = cur;
                        if (cur < min_seen)
                            min_seen = cur;
                        valid = 1'b1;
                    end
                end
            end
            if (changed)
                n_switch++;
            if (entered)
                n_lockouts++;
            r.flags.active_range    = range_sel;
            r.flags.range_changed   = changed;
            r.flags.recal_request   = recal;
            r.flags.locked_out      = uv_lock;
            r.flags.lockout_entered = entered;
            r.flags.reading_valid   = valid;
            r.max_cur = max_seen;
            r.min_cur = min_seen;
            r.total   = recal_cnt;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic signed [63:0] e, logic signed [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(t_meter_result act);
            t_meter_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with nothing expected, actual %h", $time, act);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            cmp_field("active_range", want.flags.active_range, act.flags.active_range);
            cmp_field("range_changed", want.flags.range_changed, act.flags.range_changed);
            cmp_field("recal_request", want.flags.recal_request, act.flags.recal_request);
            cmp_field("locked_out", want.flags.locked_out, act.flags.locked_out);
            cmp_field("lockout_entered", want.flags.lockout_entered,
                      act.flags.lockout_entered);
            cmp_field("reading_valid", want.flags.reading_valid, act.flags.reading_valid);
            cmp_field("max_current", $signed(want.max_cur), $signed(act.max_cur));
            cmp_field("min_current", $signed(want.min_cur), $signed(act.min_cur));
            cmp_field("recal_total", want.total, act.total);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    shar_cfg_if                      cfg_ch ();
    shar_in_if  #(.CURRENT_BITS(CB)) in_ch ();
    shar_out_if #(.CURRENT_BITS(CB)) out_ch ();

    shunt_autorange_uvlo_minmax_unit #(.CURRENT_BITS(CB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    meter_scoreboard sb = new;
    int tx_idle_pct = 14;
    int rx_idle_pct = 49;
    int rx_hold = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("** shunt_autorange_uvlo_minmax_unit: FAILED **");
        $finish;
    end

    // result side: random stalls, long hold-off on request, check every beat taken
    initial begin : result_sink
        t_meter_result got;
        forever begin
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.flags.active_range    = out_ch.active_range;
                got.flags.range_changed   = out_ch.range_changed;
                got.flags.recal_request   = out_ch.recal_request;
                got.flags.locked_out      = out_ch.locked_out;
                got.flags.lockout_entered = out_ch.lockout_entered;
                got.flags.reading_valid   = out_ch.reading_valid;
                got.max_cur = out_ch.max_current;
                got.min_cur = out_ch.min_current;
                got.total   = out_ch.recal_total;
                sb.check_result(got);
            end
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_item(t_op op, logic signed [SHUNT_W-1:0] shunt,
                             logic signed [CB-1:0] cur, logic [MV_W-1:0] bus);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.shunt_uv  <= shunt;
        in_ch.sense_ua  <= cur;
        in_ch.bus_mv    <= bus;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, shunt, cur, bus);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.apply_reg(idx, d);
    endtask

    task automatic load_thresholds(int enter_mv, int exit_mv, logic [THR_W-1:0] d0,
                                   logic [THR_W-1:0] d1, logic [THR_W-1:0] u1,
                                   logic [THR_W-1:0] u2);
        cfg_write(CFG_UVLO_ENTER, CFG_DAT_W'(enter_mv));
        cfg_write(CFG_UVLO_EXIT, CFG_DAT_W'(exit_mv));
        cfg_write(CFG_DOWN_R0, d0);
        cfg_write(CFG_DOWN_R1, d1);
        cfg_write(CFG_UP_R1, u1);
        cfg_write(CFG_UP_R2, u2);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // current: mostly close to a live threshold, some negatives, extremes and noise
    function automatic logic signed [CB-1:0] pick_current();
        logic signed [CB-1:0] raw;
        longint v;
        longint base;
        int r;
        r = $urandom_range(0, 99);
        raw = CB'($urandom);
        if (r < 7) begin
            v = raw;
        end else if (r < 13) begin
            case ($urandom_range(0, 4))
                0: v = CUR_HI;
                1: v = CUR_LO;
                2: v = 1;
                3: v = -1;
                default: v = 0;
            endcase
        end else if (r < 20) begin
            v = -longint'($urandom_range(1, 2000));
        end else begin
            case ($urandom_range(0, 3))
                0: base = longint'(sb.thr.down_from_range0);
                1: base = longint'(sb.thr.down_from_range1);
                2: base = longint'(sb.thr.up_from_range1);
                default: base = longint'(sb.thr.up_from_range2);
            endcase
            if ($urandom_range(0, 1))
                v = base + longint'($urandom_range(0, 6)) - 3;
            else
                v = base + longint'($urandom_range(0, 6000)) - 3000;
        end
        if (v > CUR_HI)
            v = CUR_HI;
        if (v < CUR_LO)
            v = CUR_LO;
        return v[CB-1:0];
    endfunction

    // bus voltage: mostly healthy, often at the lockout edges
    function automatic logic [MV_W-1:0] pick_bus();
        int r;
        int lo;
        int v;
        r = $urandom_range(0, 99);
        lo = (sb.thr.uvlo_enter_mv > sb.thr.uvlo_exit_mv) ?
             int'(sb.thr.uvlo_enter_mv) : int'(sb.thr.uvlo_exit_mv);
        if (r < 10)
            v = $urandom_range(0, MV_TOP);
        else if (r < 35)
            v = ($urandom_range(0, 1) ? int'(sb.thr.uvlo_enter_mv) : int'(sb.thr.uvlo_exit_mv))
                + int'($urandom_range(0, 6)) - 3;
        else
            v = $urandom_range(lo, MV_TOP);
        if (v < 0)
            v = 0;
        if (v > MV_TOP)
            v = MV_TOP;
        return v[MV_W-1:0];
    endfunction

    task automatic random_item();
        logic signed [SHUNT_W-1:0] shunt;
        int r;
        r = $urandom_range(0, 99);
        shunt = SHUNT_W'($urandom);
        if (r < 4) begin
            send_item(OP_CLEAR, shunt, pick_current(), pick_bus());
        end else if (r < 19) begin
            // zero current with live shunt voltage
            if (shunt == 0)
                shunt = 1;
            send_item(OP_SAMPLE, shunt, 0, pick_bus());
        end else if (r < 21) begin
            send_item(OP_SAMPLE, 0, 0, pick_bus());
        end else begin
            send_item(OP_SAMPLE, shunt, pick_current(), pick_bus());
        end
    endtask

    task automatic run_phase(int n_items, int pause_at, int hold_at);
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at)
                drain();
            if (i == hold_at)
                rx_hold = 160;
            random_item();
        end
        drain();
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // stimulus
    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_SAMPLE;
        in_ch.shunt_uv   <= '0;
        in_ch.sense_ua   <= '0;
        in_ch.bus_mv     <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_UVLO_ENTER;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();
        @(posedge i_clk);

        // directed walk through every range move, lockout edge, recal and clear
        set_idling(14, 49);
        send_item(OP_SAMPLE, 0, 90000, 5000);
        send_item(OP_SAMPLE, 524287, CUR_TOP, MV_W'(MV_TOP));
        send_item(OP_SAMPLE, 10, 80000, 5000);
        send_item(OP_SAMPLE, 10, 100001, 5000);
        send_item(OP_SAMPLE, 10, 80001, 5000);
        send_item(OP_SAMPLE, 10, 80000, 5000);
        send_item(OP_SAMPLE, 10, 100000, 5000);
        send_item(OP_SAMPLE, 10, 8000, 5000);
        send_item(OP_SAMPLE, 10, 10000, 5000);
        send_item(OP_SAMPLE, 10, 10001, 5000);
        send_item(OP_SAMPLE, -524288, 0, 5000);
        send_item(OP_SAMPLE, 0, 0, 5000);
        send_item(OP_SAMPLE, 10, -1, 5000);
        send_item(OP_SAMPLE, 10, 5000, 1499);
        send_item(OP_SAMPLE, 10, 5000, 1500);
        send_item(OP_SAMPLE, 10, 50000, 1199);
        send_item(OP_SAMPLE, 10, 90000, 1500);
        send_item(OP_SAMPLE, 10, 90000, 1200);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_SAMPLE, 10, CUR_BOT, 0);
        send_item(OP_SAMPLE, 10, CUR_BOT, MV_W'(MV_TOP));
        send_item(OP_SAMPLE, 1, 9000, MV_W'(MV_TOP));
        send_item(OP_CLEAR, -1, -1, 0);
        drain();

        // tighter window, with a full pause mid-phase
        load_thresholds(3000, 3300, 50000, 5000, 60000, 6000);
        run_phase(320, 160, -1);

        // all thresholds at zero
        load_thresholds(0, 0, '0, '0, '0, '0);
        run_phase(320, -1, -1);

        // all thresholds at their top
        set_idling(49, 14);
        load_thresholds(MV_TOP, MV_TOP, THR_TOP, THR_TOP, THR_TOP, THR_TOP);
        run_phase(320, -1, -1);

        // inverted hysteresis bands
        load_thresholds(5000, 100, 200000, 150000, 1000, 500);
        run_phase(320, -1, -1);

        // reset values, sink held off long enough to back up the input
        set_idling(0, 0);
        load_thresholds(int'(UVLO_ENTER_RST), int'(UVLO_EXIT_RST), DOWN_R0_RST, DOWN_R1_RST,
                        UP_R1_RST, UP_R2_RST);
        run_phase(320, -1, 100);

        // random threshold set
        load_thresholds($urandom_range(0, 4000), $urandom_range(0, 4000),
                        THR_W'($urandom_range(0, 300000)), THR_W'($urandom_range(0, 30000)),
                        THR_W'($urandom_range(0, 300000)), THR_W'($urandom_range(0, 30000)));
        run_phase(320, -1, -1);

        repeat (4) @(posedge i_clk);
        $display("checked %0d result beats over seven threshold sets and three idle patterns",
                 sb.n_checked);
        $display("seen: %0d range switches, %0d lockout entries, %0d recal beats, %0d clears",
                 sb.n_switch, sb.n_lockouts, sb.n_recal, sb.n_clears);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** shunt_autorange_uvlo_minmax_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending());
            $display("** shunt_autorange_uvlo_minmax_unit: FAILED **");
        end
        $finish;
    end

endmodule
